// ===== sv/tlpq_pkg.sv =====
// Shared types, sizes and codes for the three-class priority queue.
// No dependencies; used by every module of the block.
package tlpq_pkg;

    localparam int CAPACITY   = 16;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int NUM_CLS    = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam int KEY_W    = 40;
    localparam int CLS_W    = 2;
    localparam int AGE_W    = 8;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 3;
    localparam int DATA_W   = 72;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [CLS_W-1:0] CLS_URGENT = 2'd0;
    localparam logic [CLS_W-1:0] CLS_MIDDLE = 2'd1;
    localparam logic [CLS_W-1:0] CLS_LOW    = 2'd2;
    localparam logic [CLS_W-1:0] CLS_SPARE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic             remove;
        logic [KEY_W-1:0] key;
        logic [CLS_W-1:0] cls;
        logic [AGE_W-1:0] age;
        logic [TAG_W-1:0] tag;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [CLS_W-1:0]    cls;
        logic [AGE_W-1:0]    age;
        logic [TAG_W-1:0]    tag;
    } result_t;

endpackage

// ===== sv/tlpq_front.sv =====
// Front end: accepts command words, folds the spare class into low,
// and holds them in a short queue for the back end. Depends on tlpq_pkg.
module tlpq_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tlpq_pkg::cmd_t         in_cmd,
    output logic                   q_valid,
    input  logic                   q_pop,
    output tlpq_pkg::cmd_t         q_cmd
);

    tlpq_pkg::cmd_t                      mem_reg [tlpq_pkg::FIFO_DEPTH];
    logic [tlpq_pkg::PTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [tlpq_pkg::PTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [tlpq_pkg::FCNT_W-1:0]         cnt_reg, cnt_next;
    tlpq_pkg::cmd_t                      cls_cmd;
    logic                                push, pop;

    assign in_ready = (cnt_reg != tlpq_pkg::FCNT_W'(tlpq_pkg::FIFO_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = mem_reg[rd_ptr_reg];
    assign push     = in_valid & in_ready;
    assign pop      = q_pop & q_valid;

    always_comb begin
        cls_cmd = in_cmd;
        if (in_cmd.cls == tlpq_pkg::CLS_SPARE) begin
            cls_cmd.cls = tlpq_pkg::CLS_LOW;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == tlpq_pkg::PTR_W'(tlpq_pkg::FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == tlpq_pkg::PTR_W'(tlpq_pkg::FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

endmodule

// ===== sv/tlpq_back.sv =====
// Back end: slot store, per-class order and counts, and the result register.
// Executes one queued command per cycle unless a result waits. Depends on tlpq_pkg.
module tlpq_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_pop,
    input  tlpq_pkg::cmd_t      q_cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output tlpq_pkg::result_t   res
);

    localparam int N = tlpq_pkg::CAPACITY;

    logic [N-1:0]                       valid_reg, valid_next;
    logic [tlpq_pkg::KEY_W-1:0]         key_reg   [N];
    logic [tlpq_pkg::CLS_W-1:0]         cls_reg   [N];
    logic [tlpq_pkg::AGE_W-1:0]         age_reg   [N];
    logic [tlpq_pkg::TAG_W-1:0]         tag_reg   [N];
    logic [tlpq_pkg::SLOT_W-1:0]        arr_reg   [N];
    logic [tlpq_pkg::CNT_W-1:0]         cnt_reg   [tlpq_pkg::NUM_CLS];

    logic                               out_valid_reg;
    tlpq_pkg::result_t                  out_reg, out_next;

    logic [N-1:0]                       match;
    logic                               dup, full, empty;
    logic [tlpq_pkg::SLOT_W-1:0]        free_idx, pick_idx;
    logic [tlpq_pkg::CLS_W-1:0]         sel_cls;
    logic                               do_ins, do_rem;

    assign q_pop     = q_valid & (~out_valid_reg | res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            match[i] = valid_reg[i] & (key_reg[i] == q_cmd.key);
        end
    end

    assign dup  = |match;
    assign full = &valid_reg;

    always_comb begin
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = tlpq_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        empty   = 1'b0;
        sel_cls = tlpq_pkg::CLS_URGENT;
        priority if (cnt_reg[tlpq_pkg::CLS_URGENT] != '0) begin
            sel_cls = tlpq_pkg::CLS_URGENT;
        end else if (cnt_reg[tlpq_pkg::CLS_MIDDLE] != '0) begin
            sel_cls = tlpq_pkg::CLS_MIDDLE;
        end else if (cnt_reg[tlpq_pkg::CLS_LOW] != '0) begin
            sel_cls = tlpq_pkg::CLS_LOW;
        end else begin
            empty = 1'b1;
        end
    end

    always_comb begin
        pick_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (valid_reg[i] && cls_reg[i] == sel_cls && arr_reg[i] == '0) begin
                pick_idx = tlpq_pkg::SLOT_W'(i);
            end
        end
    end

    assign do_ins = q_pop & (q_cmd.remove == tlpq_pkg::CMD_INSERT) & ~dup & ~full;
    assign do_rem = q_pop & (q_cmd.remove == tlpq_pkg::CMD_REMOVE) & ~empty;

    always_comb begin
        out_next = '0;
        if (q_cmd.remove == tlpq_pkg::CMD_REMOVE) begin
            if (empty) begin
                out_next.status = tlpq_pkg::ST_EMPTY;
            end else begin
                out_next.status = tlpq_pkg::ST_REMOVED;
                out_next.key    = key_reg[pick_idx];
                out_next.cls    = cls_reg[pick_idx];
                out_next.age    = age_reg[pick_idx];
                out_next.tag    = tag_reg[pick_idx];
            end
        end else if (dup) begin
            out_next.status = tlpq_pkg::ST_DUPLICATE;
        end else if (full) begin
            out_next.status = tlpq_pkg::ST_FULL;
        end else begin
            out_next.status = tlpq_pkg::ST_INSERTED;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (do_ins) begin
            valid_next[free_idx] = 1'b1;
        end
        if (do_rem) begin
            valid_next[pick_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < tlpq_pkg::NUM_CLS; c++) begin
                cnt_reg[c] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            if (q_pop) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (do_ins) begin
                cnt_reg[q_cmd.cls] <= cnt_reg[q_cmd.cls] + 1'b1;
            end
            if (do_rem) begin
                cnt_reg[sel_cls] <= cnt_reg[sel_cls] - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= out_next;
        end
        if (do_ins) begin
            key_reg[free_idx] <= q_cmd.key;
            cls_reg[free_idx] <= q_cmd.cls;
            age_reg[free_idx] <= q_cmd.age;
            tag_reg[free_idx] <= q_cmd.tag;
            arr_reg[free_idx] <= cnt_reg[q_cmd.cls][tlpq_pkg::SLOT_W-1:0];
        end
        if (do_rem) begin
            for (int i = 0; i < N; i++) begin
                if (valid_reg[i] && cls_reg[i] == sel_cls && arr_reg[i] != '0) begin
                    arr_reg[i] <= arr_reg[i] - 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/three_level_priority_queue.sv =====
// Top level of the three-class priority queue: stream ports, front end
// and back end. Depends on tlpq_pkg, tlpq_front and tlpq_back.
//
//  channel  | dir | tdata                                   | tuser
//  ---------+-----+-----------------------------------------+--------------
//  s_       | in  | entry_key, urgency, entry_age, entry_tag | command
//  m_       | out | out_key, out_urgency, out_age, out_tag   | status
//
// One word in and one word out per cycle sustained while m_tready is held high; a
// command is written into the command queue, then popped, with the slot update and
// result register written on the same edge, and the result word is then held until taken.
// Key match, free-slot search and class pick run across all slots at once.
// Reset empties the queue; s_tready drops only when the 4-word command
// queue fills while m_tready is held low.
module three_level_priority_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // entry_key[39:0], urgency[41:40], entry_age[49:42],
                                   // entry_tag[65:50], zero[71:66]
    input  logic [0:0]  s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_key[39:0], out_urgency[41:40], out_age[49:42],
                                   // out_tag[65:50], zero[71:66]
    output logic [2:0]  m_tuser    // status[2:0]
);

    tlpq_pkg::cmd_t     in_cmd, q_cmd;
    tlpq_pkg::result_t  res;
    logic               q_valid, q_pop;

    always_comb begin
        in_cmd.remove = s_tuser[0];
        in_cmd.key    = s_tdata[39:0];
        in_cmd.cls    = s_tdata[41:40];
        in_cmd.age    = s_tdata[49:42];
        in_cmd.tag    = s_tdata[65:50];
    end

    tlpq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    tlpq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {6'd0, res.tag, res.age, res.cls, res.key};
    assign m_tuser = res.status;

endmodule

// ===== verif/three_level_priority_queue_tb.sv =====
// Self-checking bench for the three-class priority queue: bursty stream driver,
// stalling result monitor and an in-bench model of per-class FIFO order.
// Depends on tlpq_pkg and three_level_priority_queue.
module three_level_priority_queue_tb;
    import tlpq_pkg::*;

    localparam int RANDOM_WORDS = 1525;
    localparam int IDLE_LIMIT   = 1000;
    localparam int KEY_POOL     = 24;

    typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;

    cmd_t        command_backlog[$];
    cmd_t        queued_entries[$];
    result_t     pending_results[$];
    cmd_t        offered;
    logic [KEY_W-1:0] key_pool[KEY_POOL];

    int          mismatches = 0;
    int          words_in   = 0;
    int          burst_left = 0;
    int          gap_left   = 0;
    int          idle_cycles = 0;
    int          cycle_count = 0;
    int          hold_left  = 0;
    int          hold_at    = 300;
    ready_mode_t ready_mode = READY_ALWAYS;

    three_level_priority_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Strict priority across classes, arrival order within a class.
    function automatic result_t queue_response(cmd_t c);
        result_t          r;
        cmd_t             e;
        int               hit;
        int               p;
        logic [CLS_W-1:0] cls;
        r = '0;
        hit = -1;
        if (c.remove == CMD_REMOVE) begin
            for (p = 0; p < NUM_CLS && hit < 0; p++) begin
                foreach (queued_entries[i]) begin
                    if (hit < 0 && queued_entries[i].cls == p)
                        hit = i;
                end
            end
            if (hit < 0) begin
                r.status = ST_EMPTY;
            end else begin
                e = queued_entries[hit];
                queued_entries.delete(hit);
                r.status = ST_REMOVED;
                r.key = e.key;
                r.cls = e.cls;
                r.age = e.age;
                r.tag = e.tag;
            end
        end else begin
            cls = (c.cls == CLS_SPARE) ? CLS_LOW : c.cls;
            foreach (queued_entries[i]) begin
                if (queued_entries[i].key == c.key)
                    hit = i;
            end
            if (hit >= 0) begin
                r.status = ST_DUPLICATE;
            end else if (queued_entries.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                e = c;
                e.cls = cls;
                queued_entries.push_back(e);
                r.status = ST_INSERTED;
            end
        end
        return r;
    endfunction

    task automatic add_insert(logic [KEY_W-1:0] key, logic [CLS_W-1:0] cls,
                              logic [AGE_W-1:0] age, logic [TAG_W-1:0] tag);
        cmd_t c;
        c.remove = CMD_INSERT;
        c.key = key;
        c.cls = cls;
        c.age = age;
        c.tag = tag;
        command_backlog.push_back(c);
    endtask

    task automatic add_remove();
        cmd_t c;
        c = '0;
        c.remove = CMD_REMOVE;
        c.key = KEY_W'({$urandom, $urandom});
        c.cls = CLS_W'($urandom_range(3, 0));
        c.age = AGE_W'($urandom);
        c.tag = TAG_W'($urandom);
        command_backlog.push_back(c);
    endtask

    always @(posedge aclk) begin : drive_proc
        cmd_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_results.push_back(queue_response(offered));
                words_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (command_backlog.size() != 0) begin
                    nxt = command_backlog.pop_front();
                    offered = nxt;
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'b0, nxt.tag, nxt.age, nxt.cls, nxt.key};
                    s_tuser <= nxt.remove;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(40, 1);
                        gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : ready_proc
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            cycle_count++;
            if (cycle_count % 64 == 0)
                ready_mode = ready_mode_t'($urandom_range(3, 0));
            if (hold_left == 0 && words_in >= hold_at) begin
                hold_left = 160;
                hold_at += 700;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    READY_ALWAYS:   m_tready <= 1'b1;
                    READY_COIN:     m_tready <= ($urandom_range(1, 0) == 1);
                    READY_SPARSE:   m_tready <= ($urandom_range(3, 0) == 0);
                    default:        m_tready <= (cycle_count % 8 < 5);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : check_proc
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("status: expected no word, got %0d", m_tuser);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatches++;
                end
                if (m_tdata[39:0] !== want.key) begin
                    $error("out_key: expected %h, got %h", want.key, m_tdata[39:0]);
                    mismatches++;
                end
                if (m_tdata[41:40] !== want.cls) begin
                    $error("out_urgency: expected %0d, got %0d", want.cls, m_tdata[41:40]);
                    mismatches++;
                end
                if (m_tdata[49:42] !== want.age) begin
                    $error("out_age: expected %0d, got %0d", want.age, m_tdata[49:42]);
                    mismatches++;
                end
                if (m_tdata[65:50] !== want.tag) begin
                    $error("out_tag: expected %h, got %h", want.tag, m_tdata[65:50]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog_proc
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus_proc
        int               n;
        int               insert_pct;
        logic [KEY_W-1:0] key;

        // empty remove, extremes, spare class, duplicate, fill to capacity
        add_remove();
        add_insert(40'h0, CLS_URGENT, 8'h00, 16'h0000);
        add_insert(40'hFF_FFFF_FFFF, CLS_SPARE, 8'hFF, 16'hFFFF);
        add_insert(40'h0, CLS_MIDDLE, 8'h5A, 16'h1234);
        for (n = 0; n < 14; n++)
            add_insert(40'h13_5724_6800 + KEY_W'(n) * 40'h11_1111_1111, CLS_W'(n % 4),
                       AGE_W'(n * 17), TAG_W'(n * 4679));
        add_insert(40'hFF_FFFF_FFFF, CLS_URGENT, 8'h01, 16'h0001);
        add_insert(40'h55_5555_5555, CLS_MIDDLE, 8'hAA, 16'hAAAA);
        for (n = 0; n < 5; n++)
            add_remove();

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 2; n < KEY_POOL; n++)
            key_pool[n] = KEY_W'({$urandom, $urandom});

        insert_pct = 50;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0)
                insert_pct = ($urandom_range(2, 0) == 0) ? 25 :
                             ($urandom_range(1, 0) == 0) ? 50 : 80;
            if ($urandom_range(99, 0) < insert_pct) begin
                if ($urandom_range(1, 0) == 0)
                    key = key_pool[$urandom_range(KEY_POOL - 1, 0)];
                else
                    key = KEY_W'({$urandom, $urandom});
                add_insert(key, CLS_W'($urandom_range(3, 0)), AGE_W'($urandom),
                           TAG_W'($urandom));
            end else begin
                add_remove();
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (command_backlog.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
